/* design/prb_pkg.sv */
package prb_pkg;

    localparam int POS_W = 34;
    localparam int ADDR_W = 4;
    localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        REG_RANGE_START = 2'd0,
        REG_RANGE_END   = 2'd1,
        REG_BASES       = 2'd2,
        REG_FIXED_MODE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [30:0] range_start;
        logic [30:0] range_end;
        logic [15:0] bin_len;
        logic        fixed_mode;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_CLOSE,
        ST_END,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic latch;
        logic set_fin;
        logic skip_near;
        logic split;
        logic take;
        logic div_start;
        logic load_nxt_div;
        logic emit;
        logic open_nxt;
        logic restart;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic fin;
        logic at_end;
        logic y2_before;
        logic y1_after;
        logic far;
        logic split_ok;
        logic y2_over;
        logic last;
        logic score_pos;
        logic can_emit;
        logic out_free;
        logic pend_valid;
        logic div_busy;
    } sts_t;

    function automatic logic [30:0] sat_pos(input pos_t v);
        logic [30:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > pos_t'(POS_MAX)) begin
            r = POS_MAX;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

    function automatic logic [32:0] abs33(input logic signed [31:0] s);
        logic signed [32:0] w;
        w = 33'(s);
        return (w < 0) ? 33'(-w) : 33'(w);
    endfunction

endpackage

/* design/prb_regs.sv */
module prb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output prb_pkg::cfg_t                cfg,
    output logic                         cfg_wr
);
    import prb_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;
    logic     wr_reg;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    // restart in the cycle after the write so the new values are in place
    assign cfg_wr = wr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= 1'b0;
        end else begin
            wr_reg <= wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_start <= '0;
            cfg_reg.range_end   <= '0;
            cfg_reg.bin_len     <= 16'd1;
            cfg_reg.fixed_mode  <= 1'b0;
        end else if (wr) begin
            case (idx)
                REG_RANGE_START: cfg_reg.range_start <= pwdata[30:0];
                REG_RANGE_END:   cfg_reg.range_end   <= pwdata[30:0];
                REG_BASES:       cfg_reg.bin_len     <= pwdata[15:0];
                REG_FIXED_MODE:  cfg_reg.fixed_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RANGE_START: prdata = {1'b0, cfg_reg.range_start};
            REG_RANGE_END:   prdata = {1'b0, cfg_reg.range_end};
            REG_BASES:       prdata = {16'd0, cfg_reg.bin_len};
            REG_FIXED_MODE:  prdata = {31'd0, cfg_reg.fixed_mode};
            default:         prdata = '0;
        endcase
    end

endmodule

/* design/prb_div.sv */
module prb_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] rem
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    assign busy = busy_reg;
    assign rem  = rem_reg[15:0];

    // one bit of restoring remainder per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[30:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule

/* design/prb_ctrl.sv */
module prb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  prb_pkg::sts_t sts,
    output prb_pkg::cmd_t cmd
);
    import prb_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] clos_reg, clos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            clos_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clos_reg  <= clos_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        clos_next  = clos_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    clos_next  = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.fin) begin
                    state_next = ST_END;
                end else if (sts.at_end) begin
                    cmd.set_fin = 1'b1;
                    state_next  = ST_END;
                end else if (clos_reg == 2'd3 || sts.y2_before) begin
                    state_next = ST_END;
                end else if (sts.y1_after) begin
                    if (sts.far) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        cmd.skip_near = 1'b1;
                        state_next    = ST_CLOSE;
                    end
                end else if (sts.split_ok) begin
                    cmd.split  = 1'b1;
                    state_next = ST_CLOSE;
                end else begin
                    cmd.take   = 1'b1;
                    state_next = sts.y2_over ? ST_CLOSE : ST_END;
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    cmd.load_nxt_div = 1'b1;
                    state_next       = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (!sts.score_pos || sts.can_emit) begin
                    cmd.emit     = 1'b1;
                    cmd.open_nxt = 1'b1;
                    clos_next    = clos_reg + 2'd1;
                    state_next   = ST_EVAL;
                end
            end
            ST_END: begin
                if (!sts.last) begin
                    state_next = ST_FLUSH;
                end else if (sts.fin) begin
                    cmd.restart = 1'b1;
                    state_next  = ST_FLUSH;
                end else if (!sts.score_pos || sts.can_emit) begin
                    cmd.emit    = 1'b1;
                    cmd.restart = 1'b1;
                    state_next  = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* design/prb_dp.sv */
module prb_dp #(
    parameter int ID_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  prb_pkg::cfg_t      cfg,
    input  logic               cfg_wr,
    input  prb_pkg::cmd_t      cmd,
    output prb_pkg::sts_t      sts,
    input  logic [30:0]        s_src_start,
    input  logic [30:0]        s_src_end,
    input  logic signed [31:0] s_src_score,
    input  logic [ID_BITS-1:0] s_src_id,
    input  logic               s_src_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_bin_first,
    output logic [30:0]        m_bin_end,
    output logic signed [31:0] m_bin_score,
    output logic [ID_BITS-1:0] m_bin_id,
    output logic               m_bin_final
);
    import prb_pkg::*;

    pos_t y1_reg, y2_reg;
    logic signed [31:0] sc_reg;
    logic [ID_BITS-1:0] id_reg;
    logic last_reg;

    pos_t cs_reg, cs_next, ce_reg, ce_next, es_reg, es_next, ee_reg, ee_next;
    pos_t nxt_reg, nxt_next;
    logic signed [31:0] score_reg, score_next;
    logic [ID_BITS-1:0] cid_reg, cid_next;
    logic has_reg, has_next, fin_reg, fin_next;

    logic [30:0] ps_reg, ps_next, pe_reg, pe_next;
    logic signed [31:0] psc_reg, psc_next;
    logic [ID_BITS-1:0] pid_reg, pid_next;
    logic pv_reg, pv_next;

    logic [30:0] os_reg, os_next, oe_reg, oe_next;
    logic signed [31:0] osc_reg, osc_next;
    logic [ID_BITS-1:0] oid_reg, oid_next;
    logic ofin_reg, ofin_next, ov_reg, ov_next;

    pos_t bw, ce_far, start_run_pos, y2_ext, clip_end, div_a;
    logic out_free, do_emit, extend, div_busy;
    logic [15:0] div_rem;

    assign bw            = pos_t'((cfg.bin_len == 16'd0) ? 16'd1 : cfg.bin_len);
    assign ce_far        = ce_reg + bw;
    assign start_run_pos = pos_t'(cfg.range_start);
    assign out_free      = !ov_reg || m_ready;
    assign do_emit       = cmd.emit && (score_reg > 0);
    assign extend        = (y2_reg > ce_reg) && (!cfg.fixed_mode || y2_reg > ce_far);
    assign y2_ext        = extend ? y2_reg : ce_reg;
    assign clip_end      = (!cfg.fixed_mode && y2_reg < ee_reg) ? y2_reg : ee_reg;
    assign div_a         = y1_reg - cs_reg + pos_t'(1);

    prb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a[31:0]),
        .divisor  (bw[15:0]),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    always_comb begin
        sts.fin        = fin_reg;
        sts.at_end     = cs_reg >= pos_t'(cfg.range_end);
        sts.y2_before  = y2_reg < cs_reg;
        sts.y1_after   = y1_reg > ce_reg;
        sts.far        = y1_reg > ce_far;
        sts.split_ok   = cfg.fixed_mode && has_reg && (y2_reg > ce_far);
        sts.y2_over    = y2_reg > ce_reg;
        sts.last       = last_reg;
        sts.score_pos  = score_reg > 0;
        sts.can_emit   = !pv_reg || out_free;
        sts.out_free   = out_free;
        sts.pend_valid = pv_reg;
        sts.div_busy   = div_busy;
    end

    always_comb begin
        cs_next = cs_reg; ce_next = ce_reg; es_next = es_reg; ee_next = ee_reg;
        nxt_next = nxt_reg; score_next = score_reg; cid_next = cid_reg;
        has_next = has_reg; fin_next = fin_reg;
        ps_next = ps_reg; pe_next = pe_reg; psc_next = psc_reg; pid_next = pid_reg;
        pv_next = pv_reg;
        os_next = os_reg; oe_next = oe_reg; osc_next = osc_reg; oid_next = oid_reg;
        ofin_next = ofin_reg;
        ov_next = ov_reg && !m_ready;

        if (cmd.set_fin) begin
            fin_next = 1'b1;
        end
        if (cmd.skip_near) begin
            nxt_next = ce_reg + pos_t'(1);
        end
        if (cmd.load_nxt_div) begin
            nxt_next = y1_reg - pos_t'(div_rem);
        end
        if (cmd.split) begin
            ee_next  = y1_reg - pos_t'(1);
            nxt_next = y1_reg;
        end
        if (cmd.take) begin
            if (!has_reg) begin
                if (!cfg.fixed_mode) begin
                    es_next = y1_reg;
                end
                has_next = 1'b1;
                cid_next = id_reg;
            end
            if (abs33(sc_reg) > abs33(score_reg)) begin
                score_next = sc_reg;
                cid_next   = id_reg;
            end
            if (extend) begin
                ce_next = y2_reg;
                ee_next = y2_reg;
            end
            nxt_next = y2_ext + pos_t'(1);
        end

        // pending slot holds the newest bin until it is known whether it ends the item
        if (do_emit) begin
            if (pv_reg) begin
                os_next   = ps_reg;
                oe_next   = pe_reg;
                osc_next  = psc_reg;
                oid_next  = pid_reg;
                ofin_next = 1'b0;
                ov_next   = 1'b1;
            end
            ps_next  = sat_pos(es_reg);
            pe_next  = sat_pos(clip_end);
            psc_next = score_reg;
            pid_next = cid_reg;
            pv_next  = 1'b1;
        end
        if (cmd.flush) begin
            os_next   = ps_reg;
            oe_next   = pe_reg;
            osc_next  = psc_reg;
            oid_next  = pid_reg;
            ofin_next = 1'b1;
            ov_next   = 1'b1;
            pv_next   = 1'b0;
        end

        if (cmd.open_nxt) begin
            cs_next    = nxt_reg;
            ce_next    = nxt_reg + bw - pos_t'(1);
            es_next    = nxt_reg;
            ee_next    = nxt_reg + bw - pos_t'(1);
            score_next = '0;
            cid_next   = '0;
            has_next   = 1'b0;
        end
        if (cmd.restart || cfg_wr) begin
            cs_next    = start_run_pos;
            ce_next    = start_run_pos + bw - pos_t'(1);
            es_next    = start_run_pos;
            ee_next    = start_run_pos + bw - pos_t'(1);
            score_next = '0;
            cid_next   = '0;
            has_next   = 1'b0;
            fin_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg    <= '0;
            ce_reg    <= '0;
            es_reg    <= '0;
            ee_reg    <= '0;
            score_reg <= '0;
            cid_reg   <= '0;
            has_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            cs_reg    <= cs_next;
            ce_reg    <= ce_next;
            es_reg    <= es_next;
            ee_reg    <= ee_next;
            score_reg <= score_next;
            cid_reg   <= cid_next;
            has_reg   <= has_next;
            fin_reg   <= fin_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
        if (cmd.latch) begin
            y1_reg   <= pos_t'(s_src_start);
            y2_reg   <= pos_t'(s_src_end);
            sc_reg   <= s_src_score;
            id_reg   <= s_src_id;
            last_reg <= s_src_last;
        end
        nxt_reg  <= nxt_next;
        ps_reg   <= ps_next;
        pe_reg   <= pe_next;
        psc_reg  <= psc_next;
        pid_reg  <= pid_next;
        os_reg   <= os_next;
        oe_reg   <= oe_next;
        osc_reg  <= osc_next;
        oid_reg  <= oid_next;
        ofin_reg <= ofin_next;
    end

    assign m_valid     = ov_reg;
    assign m_bin_first = os_reg;
    assign m_bin_end   = oe_reg;
    assign m_bin_score = osc_reg;
    assign m_bin_id    = oid_reg;
    assign m_bin_final = ofin_reg;

    a_flush_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> (pv_reg && out_free))
        else $error("flush without room in output register");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_emit && pv_reg) |-> out_free)
        else $error("bin pushed over an unread result");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> div_busy)
        else $error("modulo unit did not start");

    a_no_open_and_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.open_nxt |-> !(cmd.take || cmd.split || cmd.latch))
        else $error("bin opened while being filled");

endmodule

/* design/peak_preserving_rebinner_top.sv */
// Peak-preserving rebinner: position-sorted source bins go in one item at a time and come out
// as bins of a programmed length from range_start, each holding the score of largest
// magnitude and its id; only bins with a positive score are sent, bin_final marks the last
// result of an item, and src_last closes the open bin and restarts the run. An item closes
// at most three bins before its end step, and the bit-serial modulo unit runs whenever a source
// jumps more than one bin width ahead; results wait behind one pending slot and the output
// register, so a stalled output stalls input. Register writes (APB, pready always high)
// restart the run and must happen while idle.
module peak_preserving_rebinner_top #(
    parameter int ID_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prb_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [30:0]                 s_src_start,
    input  logic [30:0]                 s_src_end,
    input  logic signed [31:0]          s_src_score,
    input  logic [ID_BITS-1:0]          s_src_id,
    input  logic                        s_src_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [30:0]                 m_bin_first,
    output logic [30:0]                 m_bin_end,
    output logic signed [31:0]          m_bin_score,
    output logic [ID_BITS-1:0]          m_bin_id,
    output logic                        m_bin_final
);
    import prb_pkg::*;

    cfg_t cfg;
    logic cfg_wr;
    cmd_t cmd;
    sts_t sts;

    prb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    prb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    prb_dp #(.ID_BITS(ID_BITS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cfg_wr      (cfg_wr),
        .cmd         (cmd),
        .sts         (sts),
        .s_src_start (s_src_start),
        .s_src_end   (s_src_end),
        .s_src_score (s_src_score),
        .s_src_id    (s_src_id),
        .s_src_last  (s_src_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_first (m_bin_first),
        .m_bin_end   (m_bin_end),
        .m_bin_score (m_bin_score),
        .m_bin_id    (m_bin_id),
        .m_bin_final (m_bin_final)
    );

endmodule
